@@ src/bdr_pkg.sv @@
// Shared types and constants for the bounded deque with reverse.
// No dependencies; bdr_ctrl, the top level and the testbench import this package.
`default_nettype none

package bdr_pkg;

  // Ring store geometry.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 2'd2;
  localparam logic [OP_W-1:0] OP_REVERSE   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic signed [VAL_W-1:0] value;
  } bdr_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] removed_value;
    logic [COUNT_W-1:0]      count;
  } bdr_out_t;

  // One access to the element store.
  typedef struct packed {
    logic             we;
    logic             re;
    logic [IDX_W-1:0] addr;
    logic [VAL_W-1:0] wdata;
  } bdr_mem_req_t;

  // Outcome of one request, known in the cycle it is accepted.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
    logic              removed;
  } bdr_res_t;

endpackage

`default_nettype wire

@@ src/bdr_ram.sv @@
// Generic single-port RAM with a registered read.
// No dependencies.
`default_nettype none

module bdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/bdr_ctrl.sv @@
// Ring control: front index, element count and direction flag, plus the
// store access for each request. Depends on bdr_pkg.
`default_nettype none

module bdr_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  fire_i,
  input  wire bdr_pkg::bdr_in_t      req_i,
  output      bdr_pkg::bdr_mem_req_t mem_o,
  output      bdr_pkg::bdr_res_t     res_o
);
  import bdr_pkg::*;

  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             rev_q, rev_d;

  logic             full, empty, at_start, is_insert;
  logic [IDX_W-1:0] before_front, after_front, tail_ins, tail_rem;

  // Physical slot at a logical offset from the front; offset < DEPTH.
  function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + (IDX_W + 1)'(off);
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign full         = (cnt_q == FULL_CNT);
  assign empty        = (cnt_q == '0);
  assign is_insert    = (req_i.operation == OP_INS_FRONT) || (req_i.operation == OP_INS_BACK);
  assign at_start     = (req_i.operation == OP_INS_FRONT) ? !rev_q : rev_q;
  assign before_front = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
  assign after_front  = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
  assign tail_ins     = ring_at(front_q, cnt_q);
  assign tail_rem     = ring_at(front_q, cnt_q - 1'b1);

  always_comb begin
    front_d       = front_q;
    cnt_d         = cnt_q;
    rev_d         = rev_q;
    mem_o.we      = 1'b0;
    mem_o.re      = 1'b0;
    mem_o.addr    = front_q;
    mem_o.wdata   = req_i.value;
    res_o.status  = STATUS_DONE;
    res_o.removed = 1'b0;
    case (req_i.operation)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          res_o.status = STATUS_FULL;
        end else begin
          mem_o.we = fire_i;
          cnt_d    = cnt_q + 1'b1;
          if (at_start) begin
            front_d    = before_front;
            mem_o.addr = before_front;
          end else begin
            mem_o.addr = tail_ins;
          end
        end
      end
      OP_REM_FRONT: begin
        if (empty) begin
          res_o.status = STATUS_EMPTY;
        end else begin
          mem_o.re      = fire_i;
          res_o.removed = 1'b1;
          cnt_d         = cnt_q - 1'b1;
          if (rev_q) begin
            mem_o.addr = tail_rem;
          end else begin
            front_d = after_front;
          end
        end
      end
      OP_REVERSE: begin
        rev_d = !rev_q;
      end
      default: begin
      end
    endcase
    res_o.count = cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      cnt_q   <= '0;
      rev_q   <= 1'b0;
    end else if (fire_i) begin
      front_q <= front_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FULL_CNT)
    else $error("element count exceeds depth");

  a_front_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LAST_IDX)
    else $error("front index outside the ring");

  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.we && mem_o.re))
    else $error("store read and written by one request");

  a_full_insert_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_insert && full |=> cnt_q == $past(cnt_q) && front_q == $past(front_q))
    else $error("refused insert changed the ring");

  a_empty_remove_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (req_i.operation == OP_REM_FRONT) && empty |=> cnt_q == '0)
    else $error("refused remove changed the count");

endmodule

`default_nettype wire

@@ src/bounded_deque_with_reverse.sv @@
// A result is registered and presented in the cycle after its request is accepted.
// Throughput: one request per cycle while the receiver takes each result; the
// output register is refilled in the cycle it is taken, and a remove reads the
// element store only after the last write has landed, so no forwarding is needed.
// Reset (asynchronous, active low) empties the deque and restores normal
// order; the element store itself is not cleared.
`default_nettype none

module bounded_deque_with_reverse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire bdr_pkg::bdr_in_t  in_req_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      bdr_pkg::bdr_out_t out_rsp_o
);
  import bdr_pkg::*;

  logic              fire;
  bdr_mem_req_t      mem_req;
  bdr_res_t          res;
  logic [VAL_W-1:0]  rdata;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  count_q;
  logic              removed_q;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  bdr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (in_req_i),
    .mem_o  (mem_req),
    .res_o  (res)
  );

  bdr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .re_i    (mem_req.re),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q  <= res.status;
      count_q   <= res.count;
      removed_q <= res.removed;
    end
  end

  // The store read data holds until the next remove, which cannot be
  // accepted before this result is taken.
  assign count_ext               = {{COUNT_W{1'b0}}, count_q};
  assign out_valid_o             = out_valid_q;
  assign out_rsp_o.status        = status_q;
  assign out_rsp_o.removed_value = removed_q ? rdata : '0;
  assign out_rsp_o.count         = count_ext[COUNT_W-1:0];

endmodule

`default_nettype wire

@@ sim/tb_bounded_deque_with_reverse.sv @@
// Self-checking testbench for bounded_deque_with_reverse: directed and random requests
// are checked against an in-bench deque predictor under random stalls on both sides.
// Depends on bdr_pkg (src/bdr_pkg.sv) and the block itself.
`timescale 1ns / 1ps

module tb_bounded_deque_with_reverse;
  import bdr_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 60;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned END_SLACK      = 4;
  localparam int unsigned RANDOM_OPS     = 1850;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  bdr_in_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  bdr_out_t out_rsp_o;

  // Predicted deque contents, mirrored in the same ring form as the block.
  logic [VAL_W-1:0] dq_store [DEPTH];
  int unsigned      dq_front    = 0;
  int unsigned      dq_count    = 0;
  bit               dq_reversed = 1'b0;

  bdr_out_t    rsp_expected_q[$];
  int unsigned error_count     = 0;
  int unsigned tx_max_gap      = 12;
  int unsigned rx_max_gap      = 12;
  bit          rx_hold_pending = 1'b0;

  bounded_deque_with_reverse u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the predicted deque and returns the response it yields.
  function automatic bdr_out_t deque_apply(bdr_in_t req);
    bdr_out_t    rsp;
    int unsigned slot;
    bit          at_start;
    rsp.status        = STATUS_DONE;
    rsp.removed_value = '0;
    case (req.operation)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (dq_count >= DEPTH) begin
          rsp.status = STATUS_FULL;
        end else begin
          // The logical front is the physical start unless the order is reversed.
          at_start = (req.operation == OP_INS_FRONT) ? !dq_reversed : dq_reversed;
          if (at_start) begin
            dq_front = (dq_front + DEPTH - 1) % DEPTH;
            dq_store[dq_front] = req.value;
          end else begin
            dq_store[(dq_front + dq_count) % DEPTH] = req.value;
          end
          dq_count++;
        end
      end
      OP_REM_FRONT: begin
        if (dq_count == 0) begin
          rsp.status = STATUS_EMPTY;
        end else begin
          if (!dq_reversed) begin
            slot     = dq_front;
            dq_front = (dq_front + 1) % DEPTH;
          end else begin
            slot = (dq_front + dq_count - 1) % DEPTH;
          end
          rsp.removed_value = dq_store[slot];
          dq_count--;
        end
      end
      default: dq_reversed = ~dq_reversed;
    endcase
    rsp.count = COUNT_W'(dq_count);
    return rsp;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    bdr_in_t     req;
    int unsigned gap;
    req.operation = op;
    req.value     = val;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    rsp_expected_q.push_back(deque_apply(req));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rsp_expected_q.size() != 0);
  endtask

  task automatic test_directed_ops();
    send_request(OP_REM_FRONT, 32'h1234_5678);
    send_request(OP_REVERSE, 32'hdead_beef);
    send_request(OP_REVERSE, '0);
    send_request(OP_INS_FRONT, 32'h7fff_ffff);
    send_request(OP_INS_BACK, 32'h8000_0000);
    send_request(OP_INS_FRONT, '1);
    send_request(OP_INS_BACK, '0);
    send_request(OP_REVERSE, '1);
    send_request(OP_REM_FRONT, '1);
    send_request(OP_INS_FRONT, 32'h0000_0001);
    send_request(OP_INS_BACK, 32'h5555_aaaa);
    send_request(OP_REVERSE, '0);
    repeat (6) send_request(OP_REM_FRONT, pick_value());
    send_request(OP_INS_BACK, 32'haaaa_5555);
    send_request(OP_REM_FRONT, '0);
  endtask

  // Fills the deque past its limit from both ends, then empties it past zero.
  task automatic test_fill_and_drain();
    for (int i = 0; i <= DEPTH; i++) begin
      send_request((i % 2 == 0) ? OP_INS_FRONT : OP_INS_BACK, pick_value());
      if (i % 5 == 4) send_request(OP_REVERSE, pick_value());
    end
    send_request(OP_INS_BACK, pick_value());
    send_request(OP_REVERSE, pick_value());
    send_request(OP_INS_FRONT, pick_value());
    for (int i = 0; i <= DEPTH; i++) send_request(OP_REM_FRONT, pick_value());
  endtask

  // The receiver stops for a long stretch while requests keep coming back to back.
  task automatic test_output_backpressure();
    wait_for_results();
    tx_max_gap      = 0;
    rx_hold_pending = 1'b1;
    for (int i = 0; i < 40; i++) begin
      send_request((i % 3 == 2) ? OP_REM_FRONT : (i[0] ? OP_INS_BACK : OP_INS_FRONT),
                   pick_value());
    end
    tx_max_gap = 12;
  endtask

  task automatic test_pause_until_idle();
    for (int i = 0; i < 10; i++) send_request(OP_INS_BACK, pick_value());
    wait_for_results();
    for (int i = 0; i < 10; i++) send_request(OP_REM_FRONT, pick_value());
  endtask

  task automatic test_random_ops();
    int unsigned insert_pct;
    int unsigned roll;
    insert_pct = 50;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      // Bias shifts keep the fill level sweeping between empty and full.
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 15;
          1:       insert_pct = 85;
          default: insert_pct = 50;
        endcase
      end
      if (i % 200 == 0) begin
        case ($urandom_range(0, 3))
          0:       begin tx_max_gap = 0;  rx_max_gap = 0;  end
          1:       begin tx_max_gap = 12; rx_max_gap = 0;  end
          2:       begin tx_max_gap = 0;  rx_max_gap = 12; end
          default: begin tx_max_gap = 12; rx_max_gap = 12; end
        endcase
      end
      if (i % 300 == 299) wait_for_results();
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_request(OP_REVERSE, pick_value());
      end else if ($urandom_range(0, 99) < insert_pct) begin
        send_request($urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT, pick_value());
      end else begin
        send_request(OP_REM_FRONT, pick_value());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_fill_and_drain();
    test_output_backpressure();
    test_pause_until_idle();
    test_random_ops();
    wait_for_results();
    repeat (END_SLACK) @(posedge clk_i);
    if (error_count == 0 && rsp_expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Receiver: a random stall before each response, or a long one when requested.
  initial begin : response_sink
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      stall = $urandom_range(0, rx_max_gap);
      if (rx_hold_pending) begin
        stall           = HOLD_CYCLES;
        rx_hold_pending = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : response_check
    bdr_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_expected_q.size() == 0) begin
        $error("response with no request pending: %p", out_rsp_o);
        error_count++;
      end else begin
        want = rsp_expected_q.pop_front();
        check_field("status", 32'(want.status), 32'(out_rsp_o.status));
        check_field("removed_value", want.removed_value, out_rsp_o.removed_value);
        check_field("count", 32'(want.count), 32'(out_rsp_o.count));
      end
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck = 0;
      else stuck++;
    end
    $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ bounded_deque_with_reverse.f @@
src/bdr_pkg.sv
src/bdr_ram.sv
src/bdr_ctrl.sv
src/bounded_deque_with_reverse.sv
sim/tb_bounded_deque_with_reverse.sv
